// ----- sv/snmptrap_pkg.sv -----
// ----------------------------------------------------------------------------
// snmptrap_pkg
// Types and constants shared by the SNMPv1 trap BER parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package snmptrap_pkg;

   typedef enum logic [31:0] {
      PH_IDLE     = 32'h0000_0001,
      PH_OUT_TAG  = 32'h0000_0002,
      PH_OUT_LEN  = 32'h0000_0004,
      PH_VER_HDR  = 32'h0000_0008,
      PH_VER_VAL  = 32'h0000_0010,
      PH_COM_TAG  = 32'h0000_0020,
      PH_COM_LEN  = 32'h0000_0040,
      PH_COM_BYTE = 32'h0000_0080,
      PH_PDU_TAG  = 32'h0000_0100,
      PH_PDU_LEN  = 32'h0000_0200,
      PH_ENT_TAG  = 32'h0000_0400,
      PH_ENT_LEN  = 32'h0000_0800,
      PH_ENT_BODY = 32'h0000_1000,
      PH_ADR_HDR  = 32'h0000_2000,
      PH_ADR_BYTE = 32'h0000_4000,
      PH_GEN_HDR  = 32'h0000_8000,
      PH_GEN_VAL  = 32'h0001_0000,
      PH_SPC_HDR  = 32'h0002_0000,
      PH_SPC_VAL  = 32'h0004_0000,
      PH_TT_TAG   = 32'h0008_0000,
      PH_TT_LEN   = 32'h0010_0000,
      PH_TT_BYTE  = 32'h0020_0000,
      PH_DAT_TAG  = 32'h0040_0000,
      PH_DAT_LEN  = 32'h0080_0000,
      PH_VB_TAG   = 32'h0100_0000,
      PH_VB_LEN   = 32'h0200_0000,
      PH_VO_TAG   = 32'h0400_0000,
      PH_VO_LEN   = 32'h0800_0000,
      PH_VO_BODY  = 32'h1000_0000,
      PH_VT_TYPE  = 32'h2000_0000,
      PH_VT_LEN   = 32'h4000_0000,
      PH_VT_BYTE  = 32'h8000_0000
   } phase_type;

   localparam logic [3:0] KIND_VERSION   = 4'd0;
   localparam logic [3:0] KIND_COMMUNITY = 4'd1;
   localparam logic [3:0] KIND_ENT_SUBID = 4'd2;
   localparam logic [3:0] KIND_ADDRESS   = 4'd3;
   localparam logic [3:0] KIND_GENERIC   = 4'd4;
   localparam logic [3:0] KIND_SPECIFIC  = 4'd5;
   localparam logic [3:0] KIND_TIMETICK  = 4'd6;
   localparam logic [3:0] KIND_VB_SUBID  = 4'd7;
   localparam logic [3:0] KIND_VAL_TYPE  = 4'd8;
   localparam logic [3:0] KIND_VAL_BYTE  = 4'd9;
   localparam logic [3:0] KIND_DONE      = 4'd10;
   localparam logic [3:0] KIND_ERROR     = 4'd11;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TAG       = 4'd1;
   localparam logic [3:0] ERR_LEN_FORM  = 4'd2;
   localparam logic [3:0] ERR_SIZE      = 4'd3;
   localparam logic [3:0] ERR_VERSION   = 4'd4;
   localparam logic [3:0] ERR_PREFIX    = 4'd5;
   localparam logic [3:0] ERR_OVERFLOW  = 4'd6;
   localparam logic [3:0] ERR_TRUNCATED = 4'd7;
   localparam logic [3:0] ERR_GENERIC   = 4'd8;

   localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
   localparam logic [7:0] TAG_INTEGER   = 8'h02;
   localparam logic [7:0] TAG_OCTETS    = 8'h04;
   localparam logic [7:0] TAG_OID       = 8'h06;
   localparam logic [7:0] TAG_IPADDR    = 8'h40;
   localparam logic [7:0] TAG_TIMETICKS = 8'h43;
   localparam logic [7:0] TAG_TRAP_V2   = 8'hA7;
   localparam logic [7:0] TAG_TRAP_V1   = 8'hA4;

   localparam logic [7:0] PREFIX_0 = 8'd43;
   localparam logic [7:0] PREFIX_1 = 8'd6;
   localparam logic [7:0] PREFIX_2 = 8'd1;

   localparam logic [15:0] MIN_CONTENT_LEN = 16'd9;
   localparam logic [15:0] MAX_PACKET_RESET = 16'd1500;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [31:0] record_value;
      logic        closes_element;
      logic [3:0]  error_code;
      logic        last_of_run;
   } record_type;

endpackage

`default_nettype wire

// ----- sv/snmptrap_if.sv -----
// ----------------------------------------------------------------------------
// snmptrap_req_if / snmptrap_rsp_if
// Valid/ready channels for packet bytes in and parse records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface snmptrap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_packet;
   logic       last_of_packet;

   modport source (output valid, data_byte, first_of_packet, last_of_packet, input ready);
   modport sink (input valid, data_byte, first_of_packet, last_of_packet, output ready);
endinterface

interface snmptrap_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  record_kind;
   logic [31:0] record_value;
   logic        closes_element;
   logic [3:0]  error_code;
   logic        last_of_run;

   modport source (output valid, record_kind, record_value, closes_element, error_code,
                   last_of_run, input ready);
   modport sink (input valid, record_kind, record_value, closes_element, error_code,
                 last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/snmpv1_trap_ber_parser.sv -----
// Output: a record is queued as its byte transfers, then offered on rsp_bus.
// Throughput: one byte per cycle; a byte that yields two records (a record
// plus done or error) pushes both into the queue, and the input stalls
// while the four-entry record queue has fewer than two free slots.
// Reset: parser idle, max_packet_bytes set to 1500, record queue empty.
// ----------------------------------------------------------------------------
// snmpv1_trap_ber_parser
// Byte-serial SNMPv1 trap BER parser emitting one record per decoded item.
// ----------------------------------------------------------------------------
`default_nettype none

module snmpv1_trap_ber_parser #(
   parameter int SUBID_BITS         = 32,
   parameter int LENGTH_FIELD_BYTES = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_write_enable,
   input  wire  [15:0]           csr_write_data,
   snmptrap_req_if.sink          req_bus,
   snmptrap_rsp_if.source        rsp_bus
);

   localparam int ACC_W = (SUBID_BITS > 32) ? SUBID_BITS : 32;

   snmptrap_pkg::phase_type phase_ff, phase_in, ph;
   logic [15:0] max_bytes_ff;
   logic [15:0] pos_ff, pos_in, pos_b;
   logic [15:0] end_ff, end_in, end_b;
   logic [15:0] pdu_len_ff, pdu_len_in, pdu_len_b;
   logic [15:0] dat_len_ff, dat_len_in, dat_len_b;
   logic [15:0] vb_len_ff, vb_len_in, vb_len_b;
   logic [15:0] rem_ff, rem_in, rem_b, rem_dec;
   logic [1:0]  lbl_ff, lbl_in, lbl_b;
   logic [ACC_W-1:0] acc_ff, acc_in, acc_b, acc_sub;
   logic [1:0]  pfx_ff, pfx_in, pfx_b;
   logic        ver_ff, ver_in, ver_b;

   logic        accept;
   logic [7:0]  b;
   logic        tl_done, tl_bad;
   logic [15:0] tl_len, tl_acc16;
   logic [1:0]  tl_lbl;
   logic [ACC_W-1:0] tl_acc;
   logic [16:0] total;
   logic [7:0]  pfx_exp;
   logic [3:0]  err;
   logic        pe, p_close;
   logic [3:0]  p_kind;
   logic [31:0] p_val;
   logic        te;
   logic [3:0]  t_kind, t_code;

   logic [1:0]  push_count;
   snmptrap_pkg::record_type push_a, push_b, rec_p, rec_t, head;
   logic        room_for_two, head_valid;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = room_for_two;
   assign b             = req_bus.data_byte;

   always_comb begin
      // restart state on first byte
      if (req_bus.first_of_packet) begin
         ph = snmptrap_pkg::PH_OUT_TAG;
         pos_b = 16'd0; end_b = 16'd0; pdu_len_b = 16'd0; dat_len_b = 16'd0;
         vb_len_b = 16'd0; rem_b = 16'd0; lbl_b = 2'd0; acc_b = '0; pfx_b = 2'd0;
         ver_b = 1'b0;
      end else begin
         ph = phase_ff;
         pos_b = pos_ff; end_b = end_ff; pdu_len_b = pdu_len_ff; dat_len_b = dat_len_ff;
         vb_len_b = vb_len_ff; rem_b = rem_ff; lbl_b = lbl_ff; acc_b = acc_ff;
         pfx_b = pfx_ff; ver_b = ver_ff;
      end

      // length field decode
      tl_done  = 1'b0;
      tl_bad   = 1'b0;
      tl_len   = {8'd0, b};
      tl_lbl   = lbl_b;
      tl_acc   = acc_b;
      tl_acc16 = {acc_b[7:0], b};
      if (lbl_b == 2'd0) begin
         if (!b[7]) begin
            tl_done = 1'b1;
         end else if (b[6:0] == 7'd0 || 32'(b[6:0]) > 32'(LENGTH_FIELD_BYTES)) begin
            tl_bad = 1'b1;
         end else begin
            tl_lbl = b[1:0];
            tl_acc = '0;
         end
      end else begin
         tl_acc = ACC_W'(tl_acc16);
         tl_lbl = lbl_b - 2'd1;
         tl_len = tl_acc16;
         tl_done = (tl_lbl == 2'd0);
      end

      total   = {1'b0, tl_len} + {1'b0, pos_b + 16'd1};
      rem_dec = rem_b - 16'd1;
      acc_sub = {acc_b[ACC_W-8:0], b[6:0]};
      case (pfx_b)
         2'd0:    pfx_exp = snmptrap_pkg::PREFIX_0;
         2'd1:    pfx_exp = snmptrap_pkg::PREFIX_1;
         default: pfx_exp = snmptrap_pkg::PREFIX_2;
      endcase

      phase_in = ph; pos_in = pos_b + 16'd1; end_in = end_b; pdu_len_in = pdu_len_b;
      dat_len_in = dat_len_b; vb_len_in = vb_len_b; rem_in = rem_b; lbl_in = lbl_b;
      acc_in = acc_b; pfx_in = pfx_b; ver_in = ver_b;
      err = snmptrap_pkg::ERR_NONE;
      pe = 1'b0; p_kind = snmptrap_pkg::KIND_VERSION; p_val = {24'd0, b}; p_close = 1'b0;
      te = 1'b0; t_kind = snmptrap_pkg::KIND_DONE; t_code = snmptrap_pkg::ERR_NONE;

      case (ph)
         snmptrap_pkg::PH_OUT_TAG: begin
            if (b != snmptrap_pkg::TAG_SEQUENCE) err = snmptrap_pkg::ERR_TAG;
            else phase_in = snmptrap_pkg::PH_OUT_LEN;
         end
         snmptrap_pkg::PH_OUT_LEN,
         snmptrap_pkg::PH_COM_LEN,
         snmptrap_pkg::PH_PDU_LEN,
         snmptrap_pkg::PH_ENT_LEN,
         snmptrap_pkg::PH_DAT_LEN,
         snmptrap_pkg::PH_VB_LEN,
         snmptrap_pkg::PH_VO_LEN,
         snmptrap_pkg::PH_VT_LEN: begin
            lbl_in = tl_lbl;
            acc_in = tl_acc;
            if (tl_bad) begin
               err = snmptrap_pkg::ERR_LEN_FORM;
            end else if (tl_done) begin
               case (ph)
                  snmptrap_pkg::PH_OUT_LEN: begin
                     if (total > {1'b0, max_bytes_ff} || tl_len < snmptrap_pkg::MIN_CONTENT_LEN)
                        err = snmptrap_pkg::ERR_SIZE;
                     else begin
                        end_in = total[15:0]; rem_in = 16'd1;
                        phase_in = snmptrap_pkg::PH_VER_HDR;
                     end
                  end
                  snmptrap_pkg::PH_COM_LEN: begin
                     if (tl_len > end_b) err = snmptrap_pkg::ERR_SIZE;
                     else if (tl_len == 16'd0) phase_in = snmptrap_pkg::PH_PDU_TAG;
                     else begin
                        rem_in = tl_len; phase_in = snmptrap_pkg::PH_COM_BYTE;
                     end
                  end
                  snmptrap_pkg::PH_PDU_LEN: begin
                     if (tl_len > end_b) err = snmptrap_pkg::ERR_SIZE;
                     else begin
                        pdu_len_in = tl_len; phase_in = snmptrap_pkg::PH_ENT_TAG;
                     end
                  end
                  snmptrap_pkg::PH_ENT_LEN,
                  snmptrap_pkg::PH_VO_LEN: begin
                     if (tl_len > ((ph == snmptrap_pkg::PH_ENT_LEN) ? pdu_len_b : vb_len_b))
                        err = snmptrap_pkg::ERR_SIZE;
                     else if (tl_len < 16'd3) err = snmptrap_pkg::ERR_PREFIX;
                     else begin
                        rem_in = tl_len; pfx_in = 2'd0; acc_in = '0;
                        phase_in = (ph == snmptrap_pkg::PH_ENT_LEN) ?
                                   snmptrap_pkg::PH_ENT_BODY : snmptrap_pkg::PH_VO_BODY;
                     end
                  end
                  snmptrap_pkg::PH_DAT_LEN: begin
                     if (tl_len > pdu_len_b) err = snmptrap_pkg::ERR_SIZE;
                     else begin
                        dat_len_in = tl_len; phase_in = snmptrap_pkg::PH_VB_TAG;
                     end
                  end
                  snmptrap_pkg::PH_VB_LEN: begin
                     if (tl_len > dat_len_b) err = snmptrap_pkg::ERR_SIZE;
                     else begin
                        vb_len_in = tl_len; phase_in = snmptrap_pkg::PH_VO_TAG;
                     end
                  end
                  default: begin
                     if (tl_len > vb_len_b) err = snmptrap_pkg::ERR_SIZE;
                     else if (tl_len == 16'd0) phase_in = snmptrap_pkg::PH_VB_TAG;
                     else begin
                        rem_in = tl_len; phase_in = snmptrap_pkg::PH_VT_BYTE;
                     end
                  end
               endcase
            end
         end
         snmptrap_pkg::PH_VER_HDR,
         snmptrap_pkg::PH_ADR_HDR,
         snmptrap_pkg::PH_GEN_HDR,
         snmptrap_pkg::PH_SPC_HDR: begin
            if (rem_b != 16'd0) begin
               if (b != ((ph == snmptrap_pkg::PH_ADR_HDR) ? snmptrap_pkg::TAG_IPADDR
                                                           : snmptrap_pkg::TAG_INTEGER))
                  err = snmptrap_pkg::ERR_TAG;
               else rem_in = 16'd0;
            end else if (b != ((ph == snmptrap_pkg::PH_ADR_HDR) ? 8'd4 : 8'd1)) begin
               err = snmptrap_pkg::ERR_SIZE;
            end else begin
               case (ph)
                  snmptrap_pkg::PH_VER_HDR: phase_in = snmptrap_pkg::PH_VER_VAL;
                  snmptrap_pkg::PH_GEN_HDR: phase_in = snmptrap_pkg::PH_GEN_VAL;
                  snmptrap_pkg::PH_SPC_HDR: phase_in = snmptrap_pkg::PH_SPC_VAL;
                  default: begin
                     rem_in = 16'd4; acc_in = '0; phase_in = snmptrap_pkg::PH_ADR_BYTE;
                  end
               endcase
            end
         end
         snmptrap_pkg::PH_VER_VAL: begin
            if (b > 8'd1) err = snmptrap_pkg::ERR_VERSION;
            else begin
               ver_in = b[0]; pe = 1'b1; p_kind = snmptrap_pkg::KIND_VERSION;
               phase_in = snmptrap_pkg::PH_COM_TAG;
            end
         end
         snmptrap_pkg::PH_COM_TAG: begin
            if (b != snmptrap_pkg::TAG_OCTETS) err = snmptrap_pkg::ERR_TAG;
            else phase_in = snmptrap_pkg::PH_COM_LEN;
         end
         snmptrap_pkg::PH_COM_BYTE: begin
            pe = 1'b1; p_kind = snmptrap_pkg::KIND_COMMUNITY;
            rem_in = rem_dec;
            if (rem_dec == 16'd0) phase_in = snmptrap_pkg::PH_PDU_TAG;
         end
         snmptrap_pkg::PH_PDU_TAG: begin
            if (b == snmptrap_pkg::TAG_TRAP_V2) begin
               if (!ver_b) err = snmptrap_pkg::ERR_VERSION;
            end else if (b == snmptrap_pkg::TAG_TRAP_V1) begin
               if (ver_b) err = snmptrap_pkg::ERR_VERSION;
            end else begin
               err = snmptrap_pkg::ERR_TAG;
            end
            if (err == snmptrap_pkg::ERR_NONE) phase_in = snmptrap_pkg::PH_PDU_LEN;
         end
         snmptrap_pkg::PH_ENT_TAG,
         snmptrap_pkg::PH_VO_TAG: begin
            if (b != snmptrap_pkg::TAG_OID) err = snmptrap_pkg::ERR_TAG;
            else phase_in = (ph == snmptrap_pkg::PH_ENT_TAG) ? snmptrap_pkg::PH_ENT_LEN
                                                             : snmptrap_pkg::PH_VO_LEN;
         end
         snmptrap_pkg::PH_ENT_BODY,
         snmptrap_pkg::PH_VO_BODY: begin
            rem_in = rem_dec;
            if (pfx_b != 2'd3) begin
               if (b != pfx_exp) err = snmptrap_pkg::ERR_PREFIX;
               else pfx_in = pfx_b + 2'd1;
            end else if (acc_b[ACC_W-1:SUBID_BITS-7] != '0) begin
               err = snmptrap_pkg::ERR_OVERFLOW;
            end else if (b[7]) begin
               acc_in = acc_sub;
               if (rem_dec == 16'd0) err = snmptrap_pkg::ERR_TRUNCATED;
            end else begin
               acc_in = '0;
               pe = 1'b1; p_val = acc_sub[31:0]; p_close = (rem_dec == 16'd0);
               p_kind = (ph == snmptrap_pkg::PH_ENT_BODY) ? snmptrap_pkg::KIND_ENT_SUBID
                                                          : snmptrap_pkg::KIND_VB_SUBID;
            end
            if (err == snmptrap_pkg::ERR_NONE && rem_dec == 16'd0) begin
               if (ph == snmptrap_pkg::PH_ENT_BODY) begin
                  rem_in = 16'd1; phase_in = snmptrap_pkg::PH_ADR_HDR;
               end else begin
                  phase_in = snmptrap_pkg::PH_VT_TYPE;
               end
            end
         end
         snmptrap_pkg::PH_ADR_BYTE,
         snmptrap_pkg::PH_TT_BYTE: begin
            acc_in = ACC_W'({acc_b[23:0], b});
            rem_in = rem_dec;
            p_val  = {acc_b[23:0], b};
            if (rem_dec == 16'd0) begin
               pe = 1'b1;
               if (ph == snmptrap_pkg::PH_ADR_BYTE) begin
                  p_kind = snmptrap_pkg::KIND_ADDRESS;
                  rem_in = 16'd1; phase_in = snmptrap_pkg::PH_GEN_HDR;
               end else begin
                  p_kind = snmptrap_pkg::KIND_TIMETICK;
                  phase_in = snmptrap_pkg::PH_DAT_TAG;
               end
            end
         end
         snmptrap_pkg::PH_GEN_VAL: begin
            if (b > 8'd6) err = snmptrap_pkg::ERR_GENERIC;
            else begin
               pe = 1'b1; p_kind = snmptrap_pkg::KIND_GENERIC;
               rem_in = 16'd1; phase_in = snmptrap_pkg::PH_SPC_HDR;
            end
         end
         snmptrap_pkg::PH_SPC_VAL: begin
            pe = 1'b1; p_kind = snmptrap_pkg::KIND_SPECIFIC;
            phase_in = snmptrap_pkg::PH_TT_TAG;
         end
         snmptrap_pkg::PH_TT_TAG: begin
            if (b != snmptrap_pkg::TAG_TIMETICKS) err = snmptrap_pkg::ERR_TAG;
            else phase_in = snmptrap_pkg::PH_TT_LEN;
         end
         snmptrap_pkg::PH_TT_LEN: begin
            if (b < 8'd1 || b > 8'd4) err = snmptrap_pkg::ERR_SIZE;
            else begin
               rem_in = {8'd0, b}; acc_in = '0; phase_in = snmptrap_pkg::PH_TT_BYTE;
            end
         end
         snmptrap_pkg::PH_DAT_TAG,
         snmptrap_pkg::PH_VB_TAG: begin
            if (b != snmptrap_pkg::TAG_SEQUENCE) err = snmptrap_pkg::ERR_TAG;
            else phase_in = (ph == snmptrap_pkg::PH_DAT_TAG) ? snmptrap_pkg::PH_DAT_LEN
                                                             : snmptrap_pkg::PH_VB_LEN;
         end
         snmptrap_pkg::PH_VT_TYPE: begin
            pe = 1'b1; p_kind = snmptrap_pkg::KIND_VAL_TYPE;
            phase_in = snmptrap_pkg::PH_VT_LEN;
         end
         snmptrap_pkg::PH_VT_BYTE: begin
            rem_in = rem_dec;
            pe = 1'b1; p_kind = snmptrap_pkg::KIND_VAL_BYTE; p_close = (rem_dec == 16'd0);
            if (rem_dec == 16'd0) phase_in = snmptrap_pkg::PH_VB_TAG;
         end
         default: begin
            phase_in = snmptrap_pkg::PH_IDLE;
         end
      endcase

      if (err == snmptrap_pkg::ERR_NONE && phase_in != snmptrap_pkg::PH_IDLE &&
          pos_in == end_in) begin
         if (phase_in == snmptrap_pkg::PH_VB_TAG) begin
            te = 1'b1; t_kind = snmptrap_pkg::KIND_DONE;
            phase_in = snmptrap_pkg::PH_IDLE;
         end else begin
            err = snmptrap_pkg::ERR_TRUNCATED;
         end
      end
      if (err != snmptrap_pkg::ERR_NONE) begin
         te = 1'b1; t_kind = snmptrap_pkg::KIND_ERROR; t_code = err;
         phase_in = snmptrap_pkg::PH_IDLE;
      end else if (req_bus.last_of_packet && phase_in != snmptrap_pkg::PH_IDLE) begin
         te = 1'b1; t_kind = snmptrap_pkg::KIND_ERROR;
         t_code = snmptrap_pkg::ERR_TRUNCATED;
         phase_in = snmptrap_pkg::PH_IDLE;
      end

      // idle byte without restart: no work, no record
      if (ph == snmptrap_pkg::PH_IDLE) begin
         pos_in = pos_b; rem_in = rem_b; acc_in = acc_b; lbl_in = lbl_b;
         pe = 1'b0; te = 1'b0;
      end
   end

   always_comb begin
      rec_p = '{record_kind: p_kind, record_value: p_val, closes_element: p_close,
                error_code: snmptrap_pkg::ERR_NONE, last_of_run: !te};
      rec_t = '{record_kind: t_kind, record_value: 32'd0, closes_element: 1'b0,
                error_code: t_code, last_of_run: 1'b1};
      push_a = pe ? rec_p : rec_t;
      push_b = rec_t;
      if (!accept) push_count = 2'd0;
      else push_count = {1'b0, pe} + {1'b0, te};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= snmptrap_pkg::MAX_PACKET_RESET;
      end else if (csr_write_enable) begin
         max_bytes_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= snmptrap_pkg::PH_IDLE;
         pos_ff     <= 16'd0;
         end_ff     <= 16'd0;
         pdu_len_ff <= 16'd0;
         dat_len_ff <= 16'd0;
         vb_len_ff  <= 16'd0;
         rem_ff     <= 16'd0;
         lbl_ff     <= 2'd0;
         acc_ff     <= '0;
         pfx_ff     <= 2'd0;
         ver_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         end_ff     <= end_in;
         pdu_len_ff <= pdu_len_in;
         dat_len_ff <= dat_len_in;
         vb_len_ff  <= vb_len_in;
         rem_ff     <= rem_in;
         lbl_ff     <= lbl_in;
         acc_ff     <= acc_in;
         pfx_ff     <= pfx_in;
         ver_ff     <= ver_in;
      end
   end

   snmptrap_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_a       (push_a),
      .push_b       (push_b),
      .room_for_two (room_for_two),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (rsp_bus.ready)
   );

   assign rsp_bus.valid          = head_valid;
   assign rsp_bus.record_kind    = head.record_kind;
   assign rsp_bus.record_value   = head.record_value;
   assign rsp_bus.closes_element = head.closes_element;
   assign rsp_bus.error_code     = head.error_code;
   assign rsp_bus.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// ----- sv/snmptrap_queue.sv -----
// ----------------------------------------------------------------------------
// snmptrap_queue
// Small record queue: up to two pushes per cycle, one pop per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module snmptrap_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [1:0]                push_count,
   input  wire snmptrap_pkg::record_type push_a,
   input  wire snmptrap_pkg::record_type push_b,
   output logic                      room_for_two,
   output logic                      head_valid,
   output snmptrap_pkg::record_type  head,
   input  wire                       pop
);

   snmptrap_pkg::record_type entry_ff [snmptrap_pkg::QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_pop;

   assign head_valid   = (count_ff != 3'd0);
   assign head         = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= 3'd2);
   assign do_pop       = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, do_pop};
      count_in  = count_ff + {1'b0, push_count} - {2'b00, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push_b;
      end
   end

endmodule

`default_nettype wire
